/* src/rea_pkg.sv */
package rea_pkg;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_OR = 4'd2;
  localparam logic [3:0] OP_XOR = 4'd3;
  localparam logic [3:0] OP_AND = 4'd4;
  localparam logic [3:0] OP_ORNOT = 4'd5;
  localparam logic [3:0] OP_SHL = 4'd6;
  localparam logic [3:0] OP_SHR = 4'd7;
  localparam logic [3:0] OP_MUL = 4'd8;
  localparam logic [3:0] OP_DIV = 4'd9;
  localparam logic [3:0] OP_MOD = 4'd10;

  localparam logic [2:0] CLASS_UNDEF = 3'd0;
  localparam logic [2:0] CLASS_ABS = 3'd1;
  localparam logic [2:0] CLASS_TEXT = 3'd2;
  localparam logic [2:0] CLASS_DATA = 3'd3;
  localparam logic [2:0] CLASS_BSS = 3'd4;
  localparam logic [2:0] CLASS_EXTERN = 3'd5;
  localparam logic [2:0] CLASS_ERROR = 3'd6;

  // final value select
  localparam logic [1:0] SEL_ACC = 2'd0;
  localparam logic [1:0] SEL_MUL = 2'd1;
  localparam logic [1:0] SEL_DIV = 2'd2;
  localparam logic [1:0] SEL_MOD = 2'd3;

  localparam logic REG_PASS_ONE = 1'b0;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] left_value;
    logic signed [31:0] right_value;
    logic [2:0]         left_section;
    logic [2:0]         right_section;
    logic               left_external;
    logic               right_external;
    logic               left_forward;
    logic               right_forward;
    logic               left_integer_ok;
    logic               right_integer_ok;
    logic               locations_differ;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         result_class;
    logic               result_external;
    logic               result_forward;
    logic               take_right_name;
    logic               size_error;
    logic               divide_check;
    logic               relocation_error;
  } out_word_t;

  typedef struct packed {
    logic [1:0] sel;
    logic [2:0] cls;
    logic       ext;
    logic       fwd;
    logic       take;
    logic       size_err;
    logic       divchk;
    logic       relerr;
    logic       an;
    logic       bn;
  } meta_t;

  function automatic logic [2:0] operand_class(logic [2:0] sec, logic ext, logic fwd);
    logic [2:0] c;
    if (sec == CLASS_UNDEF && ext && !fwd) c = CLASS_EXTERN;
    else if (sec > CLASS_BSS) c = CLASS_EXTERN;
    else c = sec;
    return c;
  endfunction

  function automatic logic [2:0] add_class(logic [2:0] c1, logic [2:0] c2);
    logic [2:0] r;
    if (c1 == CLASS_UNDEF || c2 == CLASS_UNDEF) r = CLASS_UNDEF;
    else if (c1 == CLASS_ABS) r = c2;
    else if (c2 == CLASS_ABS) r = c1;
    else r = CLASS_ERROR;
    return r;
  endfunction

  function automatic logic [2:0] sub_class(logic [2:0] c1, logic [2:0] c2);
    logic [2:0] r;
    if (c1 == CLASS_UNDEF || c2 == CLASS_UNDEF) r = CLASS_UNDEF;
    else if (c2 == CLASS_ABS) r = c1;
    else if (c1 == c2 && c1 != CLASS_EXTERN && c1 != CLASS_ABS) r = CLASS_ABS;
    else r = CLASS_ERROR;
    return r;
  endfunction

  function automatic logic [2:0] other_class(logic [2:0] c1, logic [2:0] c2);
    logic [2:0] r;
    if (c1 == CLASS_UNDEF || c2 == CLASS_UNDEF) r = CLASS_UNDEF;
    else if (c1 == CLASS_ABS && c2 == CLASS_ABS) r = CLASS_ABS;
    else r = CLASS_ERROR;
    return r;
  endfunction

endpackage

/* src/relocatable_expression_alu.sv */
// Relocatable expression ALU. Each input word carries one assembler expression step: an
// opcode, two 32-bit operands with their section, external, forward and integer marks, and
// a location-counter mismatch bit. The output word gives the combined value, its
// relocation class (or the relocation error class), and the size, divide and relocation
// flags. One word is taken per clock and one result leaves per clock while the result side
// is not stalled. The path is a decode register, then a row of VALUE_WIDTH identical cells
// that each retire one bit of the shift-add multiply and of the restoring divide, then
// the output register. in_ready follows out_ready while the output register is full, so
// a stall on the result side freezes the whole row. pass_one (address 0, reset 1) is
// written through the APB port and should only change while no word is in flight.
module relocatable_expression_alu
  import rea_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word,
  input  logic      psel,
  input  logic      penable,
  input  logic      pwrite,
  input  logic      paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic      pready
);

  localparam int W = VALUE_WIDTH;

  // config register
  logic pass_one_r;

  assign pready = 1'b1;
  assign prdata = {31'b0, pass_one_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_one_r <= 1'b1;
    end else if (psel && penable && pwrite && paddr == REG_PASS_ONE) begin
      pass_one_r <= pwdata[0];
    end
  end

  // whole pipeline moves together unless the output word is held
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // decode
  meta_t        f_meta;
  logic [W-1:0] f_acc, f_mcand, f_mplier, f_dq, f_mb;

  rea_front #(.W(W)) u_front (
    .word     (in_word),
    .pass_one (pass_one_r),
    .meta     (f_meta),
    .acc      (f_acc),
    .mcand    (f_mcand),
    .mplier   (f_mplier),
    .dq       (f_dq),
    .mb       (f_mb)
  );

  // stage index 0 is the decode register, 1..W the cells
  logic         vld  [W+1];
  meta_t        meta [W+1];
  logic [W-1:0] acc  [W+1];
  logic [W-1:0] mcand[W+1];
  logic [W-1:0] mplier[W+1];
  logic [W-1:0] dq   [W+1];
  logic [W-1:0] rem  [W+1];
  logic [W-1:0] mb   [W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      meta[0]   <= f_meta;
      acc[0]    <= f_acc;
      mcand[0]  <= f_mcand;
      mplier[0] <= f_mplier;
      dq[0]     <= f_dq;
      rem[0]    <= '0;
      mb[0]     <= f_mb;
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_cell
    rea_cell #(.W(W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .vld_i    (vld[i]),
      .meta_i   (meta[i]),
      .acc_i    (acc[i]),
      .mcand_i  (mcand[i]),
      .mplier_i (mplier[i]),
      .dq_i     (dq[i]),
      .rem_i    (rem[i]),
      .mb_i     (mb[i]),
      .vld_o    (vld[i+1]),
      .meta_o   (meta[i+1]),
      .acc_o    (acc[i+1]),
      .mcand_o  (mcand[i+1]),
      .mplier_o (mplier[i+1]),
      .dq_o     (dq[i+1]),
      .rem_o    (rem[i+1]),
      .mb_o     (mb[i+1])
    );
  end

  // sign fix-up and select
  meta_t        fm;
  logic [W-1:0] fv;
  out_word_t    out_nxt;

  assign fm = meta[W];

  always_comb begin
    case (fm.sel)
      SEL_MUL: fv = acc[W];
      SEL_DIV: fv = (fm.an != fm.bn) ? (~dq[W] + W'(1)) : dq[W];
      SEL_MOD: fv = fm.an ? (~rem[W] + W'(1)) : rem[W];
      default: fv = acc[W];
    endcase
    out_nxt.result_value     = 32'(fv);
    out_nxt.result_class     = fm.cls;
    out_nxt.result_external  = fm.ext;
    out_nxt.result_forward   = fm.fwd;
    out_nxt.take_right_name  = fm.take;
    out_nxt.size_error       = fm.size_err;
    out_nxt.divide_check     = fm.divchk;
    out_nxt.relocation_error = fm.relerr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[W];
    end
    if (en) begin
      out_word <= out_nxt;
    end
  end

endmodule

/* src/rea_front.sv */
module rea_front
  import rea_pkg::*;
#(
  parameter int W = 32
) (
  input  in_word_t       word,
  input  logic           pass_one,
  output meta_t          meta,
  output logic [W-1:0]   acc,
  output logic [W-1:0]   mcand,
  output logic [W-1:0]   mplier,
  output logic [W-1:0]   dq,
  output logic [W-1:0]   mb
);

  localparam int SW = $clog2(W);

  logic [W-1:0] a, b, simple_v;
  logic         an, bn, big, bzero;
  logic [2:0]   c1_raw, c1, c2, cls;
  logic [1:0]   sel;

  assign a  = W'(word.left_value);
  assign b  = W'(word.right_value);
  assign an = a[W-1];
  assign bn = b[W-1];
  assign big = bn || (b >= W'(W));
  assign bzero = (b == '0);

  assign c1_raw = operand_class(word.left_section, word.left_external, word.left_forward);

  always_comb begin
    c1 = c1_raw;
    c2 = operand_class(word.right_section, word.right_external, word.right_forward);
    if (pass_one && word.locations_differ && c1 == c2) begin
      c1 = CLASS_EXTERN;
      c2 = CLASS_EXTERN;
    end
  end

  always_comb begin
    simple_v = a;
    sel = SEL_ACC;
    cls = other_class(c1, c2);
    case (word.opcode)
      OP_ADD: begin
        simple_v = a + b;
        cls = add_class(c1, c2);
      end
      OP_SUB: begin
        simple_v = a - b;
        cls = sub_class(c1, c2);
      end
      OP_OR: simple_v = a | b;
      OP_XOR: simple_v = a ^ b;
      OP_AND: simple_v = a & b;
      OP_ORNOT: simple_v = a | ~b;
      OP_SHL: simple_v = big ? '0 : (a << b[SW-1:0]);
      OP_SHR: simple_v = big ? {W{an}} : W'($signed(a) >>> b[SW-1:0]);
      OP_MUL: sel = SEL_MUL;
      OP_DIV: if (!bzero) sel = SEL_DIV;
      OP_MOD: if (!bzero) sel = SEL_MOD;
      default: cls = CLASS_ERROR;
    endcase
  end

  always_comb begin
    meta = '0;
    meta.an = an;
    meta.bn = bn;
    acc = simple_v;
    mcand = a;
    mplier = '0;
    dq = an ? (~a + W'(1)) : a;
    mb = bn ? (~b + W'(1)) : b;
    if (!word.left_integer_ok || !word.right_integer_ok) begin
      meta.sel = SEL_ACC;
      meta.cls = c1_raw;
      meta.ext = word.left_external;
      meta.fwd = word.left_forward;
      meta.size_err = 1'b1;
      acc = a;
    end else begin
      meta.sel = sel;
      meta.cls = cls;
      meta.ext = word.left_external | word.right_external;
      meta.fwd = word.left_forward | word.right_forward;
      meta.take = (c2 == CLASS_EXTERN);
      meta.divchk = (word.opcode == OP_DIV || word.opcode == OP_MOD) && bzero;
      meta.relerr = (cls == CLASS_ERROR);
      if (sel == SEL_MUL) begin
        acc = '0;
        mplier = b;
      end
    end
  end

endmodule

/* src/rea_cell.sv */
module rea_cell
  import rea_pkg::*;
#(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         vld_i,
  input  meta_t        meta_i,
  input  logic [W-1:0] acc_i,
  input  logic [W-1:0] mcand_i,
  input  logic [W-1:0] mplier_i,
  input  logic [W-1:0] dq_i,
  input  logic [W-1:0] rem_i,
  input  logic [W-1:0] mb_i,
  output logic         vld_o,
  output meta_t        meta_o,
  output logic [W-1:0] acc_o,
  output logic [W-1:0] mcand_o,
  output logic [W-1:0] mplier_o,
  output logic [W-1:0] dq_o,
  output logic [W-1:0] rem_o,
  output logic [W-1:0] mb_o
);

  logic [W:0] trial, diff;
  logic       fits;

  // one shift-add multiply step and one restoring divide step
  assign trial = {rem_i, dq_i[W-1]};
  assign diff  = trial - {1'b0, mb_i};
  assign fits  = !diff[W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
    if (en) begin
      meta_o   <= meta_i;
      acc_o    <= acc_i + (mplier_i[0] ? mcand_i : '0);
      mcand_o  <= mcand_i << 1;
      mplier_o <= mplier_i >> 1;
      dq_o     <= {dq_i[W-2:0], fits};
      rem_o    <= fits ? diff[W-1:0] : trial[W-1:0];
      mb_o     <= mb_i;
    end
  end

endmodule

/* src/rea_checker.sv */
module rea_checker
  import rea_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  a_relerr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.relocation_error == (out_word.result_class == CLASS_ERROR)))
    else $error("relocation_error disagrees with class");

  a_size_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.size_error) |->
      (!out_word.divide_check && !out_word.take_right_name && !out_word.relocation_error))
    else $error("size error with other flags");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("output word dropped while stalled");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken during output stall");

endmodule

bind relocatable_expression_alu rea_checker u_rea_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
